[rtl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// next-cycle implication
`define CHK_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

[rtl/lbs_pkg.sv]
`default_nettype none
package lbs_pkg;

    localparam int MAX_JOINTS = 64;
    localparam int JOINT_AW   = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = FIFO_AW + 1;

    typedef enum logic [1:0] {
        OP_LOAD_POSE     = 2'd0,
        OP_LOAD_INV_BIND = 2'd1,
        OP_SKIN          = 2'd2
    } op_t;

    typedef struct packed {
        logic [1:0]         operation;
        logic [5:0]         load_joint;
        logic [3:0]         load_element;
        logic signed [31:0] load_value;
        logic [59:0]        position_xyz;
        logic [59:0]        normal_xyz;
        logic [23:0]        joint_indices;
        logic [63:0]        blend_weights;
    } in_item_t;

    typedef struct packed {
        logic [59:0] skinned_position;
        logic [59:0] skinned_normal;
        logic        saturated;
    } result_t;

endpackage
`default_nettype wire

[rtl/linear_blend_skinning.sv]
// Load items are written to the palette at acceptance.
// Vertex items: the four palette reads (one influence per cycle) on the matrix memories
// hold off the next vertex until the last is issued, so vertices overlap in the pipeline.
// Up to FIFO_DEPTH vertices in flight; results queue in a small output buffer.
// Reset (rst_n, async low) clears control and the result queue; palettes are not cleared.
`default_nettype none
module linear_blend_skinning
    import lbs_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     item_valid,
    output logic          item_stall,
    input  wire in_item_t item,
    output logic          result_valid,
    input  wire logic     result_stall,
    output result_t       result
);

    logic [15:0][31:0] pose_mem [MAX_JOINTS];
    logic [15:0][31:0] ib_mem   [MAX_JOINTS];
    logic [15:0][31:0] pose_rd_reg;
    logic [15:0][31:0] ib_rd_reg;

    logic        busy_reg, busy_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [FIFO_CW-1:0] inflight_reg, inflight_next;

    logic [59:0] vtx_pos_reg, vtx_nrm_reg;
    logic [23:0] vtx_joints_reg;
    logic [63:0] vtx_weights_reg;

    logic item_acc, vtx_acc, load_ok, res_acc;
    logic [5:0]  cur_joint;
    logic [JOINT_AW-1:0] rd_addr, wr_addr;

    // per-stage tags
    logic        s0_v_reg, s1_v_reg, s2_v_reg, s3_v_reg, s4_v_reg, s5_v_reg, s6_v_reg;
    logic        s0_first_reg, s1_first_reg, s2_first_reg, s3_first_reg;
    logic        s0_last_reg, s1_last_reg, s2_last_reg, s3_last_reg;
    logic        s0_ok_reg, s1_ok_reg, s2_ok_reg;
    logic [15:0] s0_w_reg, s1_w_reg, s2_w_reg;
    logic [59:0] s0_pos_reg, s1_pos_reg, s2_pos_reg, s3_pos_reg, s4_pos_reg, s5_pos_reg;
    logic [59:0] s0_nrm_reg, s1_nrm_reg, s2_nrm_reg, s3_nrm_reg, s4_nrm_reg, s5_nrm_reg;

    logic signed [63:0] s1_prod_reg [4][3][4];
    logic signed [31:0] s2_jel_reg  [4][3];
    logic signed [31:0] s2_jel_next [4][3];
    logic signed [48:0] s3_jw_reg   [4][3];
    logic signed [50:0] s4_acc_reg  [4][3];
    logic signed [35:0] s5_skin_reg [4][3];
    logic signed [55:0] s6_pp_reg   [3][3];
    logic signed [55:0] s6_np_reg   [3][3];
    logic signed [35:0] s6_tr_reg   [3];

    result_t            fifo_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CW-1:0] fcnt_reg;
    result_t            res_next;

    assign item_stall = (busy_reg && cnt_reg != 2'd3) ||
                        (inflight_reg == FIFO_CW'(FIFO_DEPTH));
    assign item_acc   = item_valid && !item_stall;
    assign vtx_acc    = item_acc && item.operation == OP_SKIN;
    assign load_ok    = 9'(item.load_joint) < 9'(MAX_JOINTS);
    assign wr_addr    = JOINT_AW'(item.load_joint);
    assign cur_joint  = vtx_joints_reg[cnt_reg*6 +: 6];
    assign rd_addr    = JOINT_AW'(cur_joint);
    assign res_acc    = result_valid && !result_stall;

    always_ff @(posedge clk)
    begin
        if (item_acc && load_ok && item.operation == OP_LOAD_POSE)
        begin
            pose_mem[wr_addr][item.load_element] <= item.load_value;
        end
        if (item_acc && load_ok && item.operation == OP_LOAD_INV_BIND)
        begin
            ib_mem[wr_addr][item.load_element] <= item.load_value;
        end
        pose_rd_reg <= pose_mem[rd_addr];
        ib_rd_reg   <= ib_mem[rd_addr];
    end

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (busy_reg)
        begin
            cnt_next = cnt_reg + 2'd1;
            if (cnt_reg == 2'd3)
            begin
                busy_next = 1'b0;
            end
        end
        if (vtx_acc)
        begin
            busy_next = 1'b1;
            cnt_next  = 2'd0;
        end
        inflight_next = inflight_reg + FIFO_CW'(vtx_acc) - FIFO_CW'(res_acc);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            cnt_reg      <= 2'd0;
            inflight_reg <= '0;
            s0_v_reg     <= 1'b0;
            s1_v_reg     <= 1'b0;
            s2_v_reg     <= 1'b0;
            s3_v_reg     <= 1'b0;
            s4_v_reg     <= 1'b0;
            s5_v_reg     <= 1'b0;
            s6_v_reg     <= 1'b0;
        end
        else
        begin
            busy_reg     <= busy_next;
            cnt_reg      <= cnt_next;
            inflight_reg <= inflight_next;
            s0_v_reg     <= busy_reg;
            s1_v_reg     <= s0_v_reg;
            s2_v_reg     <= s1_v_reg;
            s3_v_reg     <= s2_v_reg;
            s4_v_reg     <= s3_v_reg && s3_last_reg;
            s5_v_reg     <= s4_v_reg;
            s6_v_reg     <= s5_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (vtx_acc)
        begin
            vtx_pos_reg     <= item.position_xyz;
            vtx_nrm_reg     <= item.normal_xyz;
            vtx_joints_reg  <= item.joint_indices;
            vtx_weights_reg <= item.blend_weights;
        end
        s0_first_reg <= cnt_reg == 2'd0;
        s0_last_reg  <= cnt_reg == 2'd3;
        s0_ok_reg    <= 9'(cur_joint) < 9'(MAX_JOINTS);
        s0_w_reg     <= vtx_weights_reg[cnt_reg*16 +: 16];
        s0_pos_reg   <= vtx_pos_reg;
        s0_nrm_reg   <= vtx_nrm_reg;

        s1_first_reg <= s0_first_reg;
        s1_last_reg  <= s0_last_reg;
        s1_ok_reg    <= s0_ok_reg;
        s1_w_reg     <= s0_w_reg;
        s1_pos_reg   <= s0_pos_reg;
        s1_nrm_reg   <= s0_nrm_reg;
        s2_first_reg <= s1_first_reg;
        s2_last_reg  <= s1_last_reg;
        s2_ok_reg    <= s1_ok_reg;
        s2_w_reg     <= s1_w_reg;
        s2_pos_reg   <= s1_pos_reg;
        s2_nrm_reg   <= s1_nrm_reg;
        s3_first_reg <= s2_first_reg;
        s3_last_reg  <= s2_last_reg;
        s3_pos_reg   <= s2_pos_reg;
        s3_nrm_reg   <= s2_nrm_reg;
        s4_pos_reg   <= s3_pos_reg;
        s4_nrm_reg   <= s3_nrm_reg;
        s5_pos_reg   <= s4_pos_reg;
        s5_nrm_reg   <= s4_nrm_reg;

        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int k = 0; k < 4; k++)
                begin
                    s1_prod_reg[c][r][k] <= $signed(pose_rd_reg[k*4+r]) *
                                            $signed(ib_rd_reg[c*4+k]);
                end
                s2_jel_reg[c][r] <= s2_jel_next[c][r];
                s3_jw_reg[c][r]  <= s2_ok_reg ?
                                    s2_jel_reg[c][r] * $signed({1'b0, s2_w_reg}) : 49'sd0;
                if (s3_first_reg)
                begin
                    s4_acc_reg[c][r] <= 51'(s3_jw_reg[c][r]);
                end
                else
                begin
                    s4_acc_reg[c][r] <= s4_acc_reg[c][r] + 51'(s3_jw_reg[c][r]);
                end
                s5_skin_reg[c][r] <= 36'((s4_acc_reg[c][r] + 51'sd16384) >>> 15);
            end
        end

        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                s6_pp_reg[c][r] <= s5_skin_reg[c][r] * $signed(s5_pos_reg[c*20 +: 20]);
                s6_np_reg[c][r] <= s5_skin_reg[c][r] * $signed(s5_nrm_reg[c*20 +: 20]);
            end
            s6_tr_reg[r] <= s5_skin_reg[3][r];
        end
    end

    // joint element: round to Q16.16, saturate to 32 bits
    always_comb
    begin
        logic signed [65:0] sum;
        logic signed [49:0] sh;
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 3; r++)
            begin
                sum = 66'sd32768;
                for (int k = 0; k < 4; k++)
                begin
                    sum = sum + 66'(s1_prod_reg[c][r][k]);
                end
                sh = 50'(sum >>> 16);
                if (sh > 50'sd2147483647)
                begin
                    s2_jel_next[c][r] = 32'sh7fffffff;
                end
                else if (sh < -50'sd2147483648)
                begin
                    s2_jel_next[c][r] = 32'sh80000000;
                end
                else
                begin
                    s2_jel_next[c][r] = 32'(sh);
                end
            end
        end
    end

    // output: round to Q.8, clamp to 20 bits
    always_comb
    begin
        logic signed [59:0] ap, an;
        logic signed [43:0] ps, ns;
        res_next = '0;
        for (int r = 0; r < 3; r++)
        begin
            ap = 60'sd32768 + (60'(s6_tr_reg[r]) <<< 8);
            an = 60'sd32768;
            for (int c = 0; c < 3; c++)
            begin
                ap = ap + 60'(s6_pp_reg[c][r]);
                an = an + 60'(s6_np_reg[c][r]);
            end
            ps = 44'(ap >>> 16);
            ns = 44'(an >>> 16);
            if (ps > 44'sd524287)
            begin
                res_next.skinned_position[r*20 +: 20] = 20'h7ffff;
                res_next.saturated = 1'b1;
            end
            else if (ps < -44'sd524288)
            begin
                res_next.skinned_position[r*20 +: 20] = 20'h80000;
                res_next.saturated = 1'b1;
            end
            else
            begin
                res_next.skinned_position[r*20 +: 20] = ps[19:0];
            end
            if (ns > 44'sd524287)
            begin
                res_next.skinned_normal[r*20 +: 20] = 20'h7ffff;
                res_next.saturated = 1'b1;
            end
            else if (ns < -44'sd524288)
            begin
                res_next.skinned_normal[r*20 +: 20] = 20'h80000;
                res_next.saturated = 1'b1;
            end
            else
            begin
                res_next.skinned_normal[r*20 +: 20] = ns[19:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s6_v_reg)
        begin
            fifo_reg[wr_ptr_reg] <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fcnt_reg   <= '0;
        end
        else
        begin
            if (s6_v_reg)
            begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(1);
            end
            if (res_acc)
            begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            end
            fcnt_reg <= fcnt_reg + FIFO_CW'(s6_v_reg) - FIFO_CW'(res_acc);
        end
    end

    assign result_valid = fcnt_reg != '0;
    assign result       = fifo_reg[rd_ptr_reg];

`include "assert_macros.svh"

    `CHK_IMPL(a_inflight_bound, 1'b1, inflight_reg <= FIFO_CW'(FIFO_DEPTH))
    `CHK_IMPL(a_no_overflow, s6_v_reg, fcnt_reg < FIFO_CW'(FIFO_DEPTH) || res_acc)
    `CHK_NEXT(a_vertex_starts, vtx_acc, busy_reg && cnt_reg == 2'd0)
    `CHK_IMPL(a_result_owned, result_valid, inflight_reg >= fcnt_reg)

endmodule
`default_nettype wire
